// ===== src/slt_pkg.sv =====
// Shared types, constants and lookup functions for the skeleton line tracker.
`default_nettype none

package slt_pkg;

   // Default image size.
   localparam int IMG_WIDTH_DEF  = 128;
   localparam int IMG_HEIGHT_DEF = 128;

   // Command codes.
   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_START = 2'd1;
   localparam logic [1:0] FUNC_STEP  = 2'd2;

   // Pixel levels: a line pixel and a visited pixel.
   localparam logic [7:0] PIX_ON   = 8'd255;
   localparam logic [7:0] PIX_MARK = 8'd127;

   localparam logic [3:0] HEAD_NONE = 4'd0;

   // Ring length and candidate counts of the two neighbour searches.
   localparam logic [4:0] RING_LEN   = 5'd16;
   localparam logic [4:0] FULL_CANDS = 5'd8;
   localparam logic [4:0] HEAD_CANDS = 5'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CTR_RD,
      ST_CTR_CHK,
      ST_RING,
      ST_DECIDE,
      ST_SRCH
   } st_type;

   typedef struct packed {
      logic [1:0] func;
      logic [6:0] coord_x;
      logic [6:0] coord_y;
      logic [7:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic [6:0] pos_x;
      logic [6:0] pos_y;
      logic [3:0] heading;
      logic [3:0] crossings;
      logic       moved;
      logic       stopped;
   } rsp_type;

   // Signed offset of a probe from its base coordinate.
   typedef struct packed {
      logic signed [2:0] dx;
      logic signed [2:0] dy;
   } offset_type;

   // Probe coordinate and whether it lies inside the image.
   typedef struct packed {
      logic signed [8:0] pos_x;
      logic signed [8:0] pos_y;
      logic              inb;
   } probe_type;

   // Offset of a heading code 1..8 = N,NE,E,SE,S,SW,W,NW.
   function automatic offset_type dir_offset(input logic [3:0] d);
      offset_type o;
      case (d)
         4'd1: o = '{dx:  3'sd0, dy: -3'sd1};
         4'd2: o = '{dx:  3'sd1, dy: -3'sd1};
         4'd3: o = '{dx:  3'sd1, dy:  3'sd0};
         4'd4: o = '{dx:  3'sd1, dy:  3'sd1};
         4'd5: o = '{dx:  3'sd0, dy:  3'sd1};
         4'd6: o = '{dx: -3'sd1, dy:  3'sd1};
         4'd7: o = '{dx: -3'sd1, dy:  3'sd0};
         4'd8: o = '{dx: -3'sd1, dy: -3'sd1};
         default: o = '{dx: 3'sd0, dy: 3'sd0};
      endcase
      return o;
   endfunction

   // Ring of the 5x5 window, clockwise from the top-left corner.
   function automatic offset_type ring_offset(input logic [3:0] i);
      offset_type o;
      case (i)
         4'd0:  o = '{dx: -3'sd2, dy: -3'sd2};
         4'd1:  o = '{dx: -3'sd1, dy: -3'sd2};
         4'd2:  o = '{dx:  3'sd0, dy: -3'sd2};
         4'd3:  o = '{dx:  3'sd1, dy: -3'sd2};
         4'd4:  o = '{dx:  3'sd2, dy: -3'sd2};
         4'd5:  o = '{dx:  3'sd2, dy: -3'sd1};
         4'd6:  o = '{dx:  3'sd2, dy:  3'sd0};
         4'd7:  o = '{dx:  3'sd2, dy:  3'sd1};
         4'd8:  o = '{dx:  3'sd2, dy:  3'sd2};
         4'd9:  o = '{dx:  3'sd1, dy:  3'sd2};
         4'd10: o = '{dx:  3'sd0, dy:  3'sd2};
         4'd11: o = '{dx: -3'sd1, dy:  3'sd2};
         4'd12: o = '{dx: -3'sd2, dy:  3'sd2};
         4'd13: o = '{dx: -3'sd2, dy:  3'sd1};
         4'd14: o = '{dx: -3'sd2, dy:  3'sd0};
         default: o = '{dx: -3'sd2, dy: -3'sd1};
      endcase
      return o;
   endfunction

   // Full neighbour search order: N,E,S,W,NE,SE,SW,NW.
   function automatic logic [3:0] full_cand(input logic [2:0] k);
      logic [3:0] d;
      case (k)
         3'd0: d = 4'd1;
         3'd1: d = 4'd3;
         3'd2: d = 4'd5;
         3'd3: d = 4'd7;
         3'd4: d = 4'd2;
         3'd5: d = 4'd4;
         3'd6: d = 4'd6;
         default: d = 4'd8;
      endcase
      return d;
   endfunction

   // Heading search: straight ahead, then the two directions on either side of it.
   // Heading north tries its right-hand neighbour before its left-hand one.
   function automatic logic [3:0] head_cand(input logic [3:0] h, input logic [1:0] k);
      logic [3:0] d;
      case (k)
         2'd0: d = h;
         2'd1: d = (h == 4'd1) ? 4'd2 : h - 4'd1;
         2'd2: begin
            if (h == 4'd1) begin
               d = 4'd8;
            end else if (h == 4'd8) begin
               d = 4'd1;
            end else begin
               d = h + 4'd1;
            end
         end
         default: d = HEAD_NONE;
      endcase
      if (h == HEAD_NONE) begin
         d = HEAD_NONE;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

// ===== src/slt_probe.sv =====
// Shared probe unit: coordinate offset, image bounds check and store address.
`default_nettype none

module slt_probe
   import slt_pkg::*;
#(
   parameter int IMG_WIDTH  = IMG_WIDTH_DEF,
   parameter int IMG_HEIGHT = IMG_HEIGHT_DEF,
   parameter int ADDR_W     = $clog2(IMG_WIDTH * IMG_HEIGHT)
) (
   input  logic [6:0]        base_x,
   input  logic [6:0]        base_y,
   input  offset_type        off,
   output probe_type         probe,
   output logic [ADDR_W-1:0] addr
);

   logic signed [8:0] px;
   logic signed [8:0] py;
   logic              inb;

   // Base plus sign-extended offset.
   assign px = $signed({2'b00, base_x}) + $signed({{6{off.dx[2]}}, off.dx});
   assign py = $signed({2'b00, base_y}) + $signed({{6{off.dy[2]}}, off.dy});

   // Inside the image when both coordinates are non-negative and below the size.
   assign inb = !px[8] && !py[8] && (int'(px) < IMG_WIDTH) && (int'(py) < IMG_HEIGHT);

   assign probe = '{pos_x: px, pos_y: py, inb: inb};

   // Row-major address; parked at zero for probes outside the image.
   assign addr = inb ? ADDR_W'(ADDR_W'(py[7:0]) * ADDR_W'(IMG_WIDTH) + ADDR_W'(px[7:0]))
                     : '0;

endmodule

`default_nettype wire

// ===== src/skeleton_line_tracker.sv =====
// Top level of the skeleton line tracker: pixel store, step sequencer and result port.
// Latency: write, start and idle steps give their result in the cycle after acceptance.
// An active step reads one pixel per cycle through the single store port: center check,
// 16 ring reads and up to 8 neighbour reads.
// A new item is taken in the cycle that shows the previous result; results cannot be stalled.
// Synchronous reset clears cursor, heading and tracking; store contents are undefined until written.
`default_nettype none

module skeleton_line_tracker
   import slt_pkg::*;
#(
   parameter int IMG_WIDTH  = IMG_WIDTH_DEF,
   parameter int IMG_HEIGHT = IMG_HEIGHT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int DEPTH  = IMG_WIDTH * IMG_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);

   st_type     state_ff, state_in;
   logic [6:0] cursor_x_ff, cursor_x_in;
   logic [6:0] cursor_y_ff, cursor_y_in;
   logic [3:0] heading_ff, heading_in;
   logic       active_ff, active_in;
   logic [3:0] cross_ff, cross_in;
   logic       moved_ff, moved_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [4:0] trans_ff, trans_in;
   logic       first_ff, first_in;
   logic       prev_ff, prev_in;
   logic       srch_head_ff, srch_head_in;
   logic [3:0] cand_ff, cand_in;
   probe_type  probe_ff;
   logic [7:0] rd_ff;

   logic [6:0]        base_x;
   logic [6:0]        base_y;
   offset_type        off;
   probe_type         probe;
   logic [ADDR_W-1:0] addr;
   logic              mem_we;
   logic [7:0]        mem_wdata;
   logic [7:0]        pix;
   logic              ring_bit;
   logic [3:0]        cr;
   logic              has_head;
   logic [4:0]        cand_limit;

   logic [7:0] mem [DEPTH];

   slt_probe #(
      .IMG_WIDTH  (IMG_WIDTH),
      .IMG_HEIGHT (IMG_HEIGHT),
      .ADDR_W     (ADDR_W)
   ) u_probe (
      .base_x (base_x),
      .base_y (base_y),
      .off    (off),
      .probe  (probe),
      .addr   (addr)
   );

   // Single-port pixel store with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr] <= mem_wdata;
      end
      rd_ff <= mem[addr];
   end

   // Pixel seen by the previous probe; reads outside the image give zero.
   assign pix      = probe_ff.inb ? rd_ff : 8'd0;
   assign ring_bit = pix > PIX_MARK;
   assign cr       = trans_ff[4:1];
   assign has_head = heading_ff != HEAD_NONE;
   assign cand_limit = srch_head_ff ? HEAD_CANDS : FULL_CANDS;
   assign cand_in  = srch_head_ff ? head_cand(heading_ff, cnt_ff[1:0])
                                  : full_cand(cnt_ff[2:0]);

   // Sequencer state and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         heading_ff   <= HEAD_NONE;
         active_ff    <= 1'b0;
         cross_ff     <= '0;
         moved_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         heading_ff   <= heading_in;
         active_ff    <= active_in;
         cross_ff     <= cross_in;
         moved_ff     <= moved_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      trans_ff     <= trans_in;
      first_ff     <= first_in;
      prev_ff      <= prev_in;
      srch_head_ff <= srch_head_in;
      cand_ff      <= cand_in;
      probe_ff     <= probe;
   end

   // Next state, probe selection and store control.
   always_comb begin
      state_in     = state_ff;
      cursor_x_in  = cursor_x_ff;
      cursor_y_in  = cursor_y_ff;
      heading_in   = heading_ff;
      active_in    = active_ff;
      cross_in     = cross_ff;
      moved_in     = moved_ff;
      rsp_valid_in = 1'b0;
      cnt_in       = cnt_ff;
      trans_in     = trans_ff;
      first_in     = first_ff;
      prev_in      = prev_ff;
      srch_head_in = srch_head_ff;
      base_x       = cursor_x_ff;
      base_y       = cursor_y_ff;
      off          = '{dx: 3'sd0, dy: 3'sd0};
      mem_we       = 1'b0;
      mem_wdata    = PIX_MARK;

      case (state_ff)
         ST_IDLE: begin
            base_x = req_data.coord_x;
            base_y = req_data.coord_y;
            if (start) begin
               cross_in = '0;
               moved_in = 1'b0;
               case (req_data.func)
                  FUNC_WRITE: begin
                     mem_we       = probe.inb;
                     mem_wdata    = req_data.pixel_value;
                     rsp_valid_in = 1'b1;
                  end
                  FUNC_START: begin
                     cursor_x_in  = req_data.coord_x;
                     cursor_y_in  = req_data.coord_y;
                     heading_in   = HEAD_NONE;
                     active_in    = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  FUNC_STEP: begin
                     if (active_ff) begin
                        state_in = ST_CTR_RD;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         // Read the cursor pixel.
         ST_CTR_RD: begin
            state_in = ST_CTR_CHK;
         end

         // Stop unless the cursor pixel is on the line; otherwise mark it visited.
         ST_CTR_CHK: begin
            if (pix != PIX_ON) begin
               active_in    = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               mem_we   = 1'b1;
               cnt_in   = '0;
               trans_in = '0;
               state_in = ST_RING;
            end
         end

         // Read the ring one pixel a cycle and count changes between neighbours.
         ST_RING: begin
            off    = ring_offset(cnt_ff[3:0]);
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff != '0) begin
               prev_in = ring_bit;
            end
            if (cnt_ff == 5'd1) begin
               first_in = ring_bit;
            end
            if (cnt_ff >= 5'd2) begin
               trans_in = trans_ff + 5'(ring_bit != prev_ff);
            end
            if (cnt_ff == RING_LEN) begin
               // The last ring pixel also closes the loop back to the first.
               trans_in = trans_ff + 5'(ring_bit != prev_ff) + 5'(ring_bit != first_ff);
               state_in = ST_DECIDE;
            end
         end

         // Choose the search from the halved change count and the heading, or end the step without one.
         ST_DECIDE: begin
            cross_in = cr;
            cnt_in   = '0;
            if ((!has_head && cr <= 4'd2) || (has_head && cr == 4'd1)) begin
               srch_head_in = 1'b0;
               state_in     = ST_SRCH;
            end else if (cr >= 4'd1) begin
               if (has_head) begin
                  srch_head_in = 1'b1;
                  state_in     = ST_SRCH;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               active_in    = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         // Probe candidates in order; move to the first line pixel found.
         ST_SRCH: begin
            off    = dir_offset(cand_in);
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff != '0 && pix == PIX_ON) begin
               cursor_x_in  = probe_ff.pos_x[6:0];
               cursor_y_in  = probe_ff.pos_y[6:0];
               heading_in   = cand_ff;
               moved_in     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (cnt_ff == cand_limit) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result port.
   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = '{pos_x:     cursor_x_ff,
                        pos_y:     cursor_y_ff,
                        heading:   heading_ff,
                        crossings: cross_ff,
                        moved:     moved_ff,
                        stopped:   !active_ff};

endmodule

`default_nettype wire

// ===== src/slt_checker.sv =====
// Port-level checker for the skeleton line tracker and its bind.
`default_nettype none

module slt_checker
   import slt_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);

   // An accepted item either keeps the block busy or gives its result next cycle.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted item neither started work nor returned a result");

   // The end of an active step always shows a result.
   a_done_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("step finished without a result");

   // A result is never shown while the block is still working.
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // A move only happens while tracking stays active, with a heading set.
   a_moved_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.moved |-> !rsp_data.stopped && rsp_data.heading != HEAD_NONE)
      else $error("moved reported with tracking stopped or no heading");

   // The halved ring count cannot exceed eight.
   a_cross_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.crossings <= 4'd8)
      else $error("crossing count out of range");

endmodule

bind skeleton_line_tracker slt_checker u_slt_checker (.*);

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the skeleton line tracker: stimulus, predictor and result check.
`timescale 1ns / 1ps

module tb;
   import slt_pkg::*;

   // Compass codes of the cursor heading; no heading is HEAD_NONE.
   typedef enum logic [3:0] {
      DIR_N = 4'd1,
      DIR_NE,
      DIR_E,
      DIR_SE,
      DIR_S,
      DIR_SW,
      DIR_W,
      DIR_NW
   } compass_type;

   // The one command code that the block ignores.
   localparam logic [1:0] FUNC_BAD = 2'd3;

   // Full neighbour search, one nibble per candidate, first candidate lowest.
   localparam logic [31:0] FULL_ORDER = {DIR_NW, DIR_SW, DIR_SE, DIR_NE,
                                         DIR_W, DIR_S, DIR_E, DIR_N};

   localparam int IMG_PIXELS = IMG_WIDTH_DEF * IMG_HEIGHT_DEF;
   localparam int TOTAL_ITEMS = 850;

   logic    clock;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   skeleton_line_tracker dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Commands waiting to be driven and results waiting to arrive.
   req_type cmd_queue[$];
   rsp_type expected_pos_q[$];

   int sent_count = 0;
   int taken_count = 0;
   int fail_count = 0;
   int stim_count = 0;

   // Predictor copy of the tracker state.
   logic [7:0] pix_mem[0:IMG_PIXELS-1];
   logic [6:0] cur_x = '0;
   logic [6:0] cur_y = '0;
   logic [3:0] head = HEAD_NONE;
   bit         active = 1'b0;

   // Pixels loaded so far; the stimulus never lets the block read any other.
   bit px_loaded[0:IMG_PIXELS-1];

   function automatic bit in_image(input int x, input int y);
      return x >= 0 && y >= 0 && x < IMG_WIDTH_DEF && y < IMG_HEIGHT_DEF;
   endfunction

   function automatic int step_x(input logic [3:0] d);
      case (d)
         DIR_NE, DIR_E, DIR_SE: return 1;
         DIR_SW, DIR_W, DIR_NW: return -1;
         default: return 0;
      endcase
   endfunction

   function automatic int step_y(input logic [3:0] d);
      case (d)
         DIR_N, DIR_NE, DIR_NW: return -1;
         DIR_SE, DIR_S, DIR_SW: return 1;
         default: return 0;
      endcase
   endfunction

   // Position k of the 5x5 ring, walking clockwise from the top-left corner.
   task automatic ring_spot(input int k, output int dx, output int dy);
      if (k <= 4) begin
         dx = k - 2;
         dy = -2;
      end else if (k <= 8) begin
         dx = 2;
         dy = k - 6;
      end else if (k <= 12) begin
         dx = 10 - k;
         dy = 2;
      end else begin
         dx = -2;
         dy = 14 - k;
      end
   endtask

   // Heading search: straight on, then the two directions on either side of it.
   function automatic logic [31:0] heading_tries(input logic [3:0] h);
      logic [3:0] second;
      logic [3:0] third;
      second = (h == DIR_N) ? DIR_NE : h - 4'd1;
      if (h == DIR_N) begin
         third = DIR_NW;
      end else if (h == DIR_NW) begin
         third = DIR_N;
      end else begin
         third = h + 4'd1;
      end
      return {20'd0, third, second, h};
   endfunction

   function automatic logic [7:0] pixel_at(input int x, input int y);
      if (!in_image(x, y)) begin
         return 8'd0;
      end
      return pix_mem[y * IMG_WIDTH_DEF + x];
   endfunction

   // Move to the first candidate neighbour that holds a line pixel.
   task automatic probe_moves(input logic [31:0] cands, input int count, output bit found);
      int k;
      int nx;
      int ny;
      logic [3:0] d;
      found = 1'b0;
      for (k = 0; k < count && !found; k++) begin
         d = cands[4*k +: 4];
         nx = int'(cur_x) + step_x(d);
         ny = int'(cur_y) + step_y(d);
         if (d != HEAD_NONE && pixel_at(nx, ny) == PIX_ON) begin
            cur_x = nx[6:0];
            cur_y = ny[6:0];
            head = d;
            found = 1'b1;
         end
      end
   endtask

   // Apply one accepted item to the predictor state and form its result.
   task automatic trace_predict(input req_type r, output rsp_type e);
      int cx;
      int cy;
      int k;
      int ax;
      int ay;
      int bx;
      int by;
      int turns;
      bit moved;
      turns = 0;
      moved = 1'b0;
      case (r.func)
         FUNC_WRITE: begin
            pix_mem[{r.coord_y, r.coord_x}] = r.pixel_value;
         end
         FUNC_START: begin
            cur_x = r.coord_x;
            cur_y = r.coord_y;
            head = HEAD_NONE;
            active = 1'b1;
         end
         FUNC_STEP: begin
            if (active) begin
               cx = int'(cur_x);
               cy = int'(cur_y);
               if (pixel_at(cx, cy) != PIX_ON) begin
                  active = 1'b0;
               end else begin
                  pix_mem[{cur_y, cur_x}] = PIX_MARK;
                  // Count changes of the bright test around the ring, then halve.
                  for (k = 0; k < RING_LEN; k++) begin
                     ring_spot(k, ax, ay);
                     ring_spot((k + 1) % RING_LEN, bx, by);
                     if ((pixel_at(cx + ax, cy + ay) > PIX_MARK) !=
                         (pixel_at(cx + bx, cy + by) > PIX_MARK)) begin
                        turns++;
                     end
                  end
                  turns = turns / 2;
                  if ((head == HEAD_NONE && turns <= 2) || (head != HEAD_NONE && turns == 1)) begin
                     probe_moves(FULL_ORDER, 8, moved);
                  end else if (turns >= 1) begin
                     // A junction with no heading leaves the cursor where it is.
                     if (head != HEAD_NONE) begin
                        probe_moves(heading_tries(head), 3, moved);
                     end
                  end else begin
                     active = 1'b0;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      e.pos_x = cur_x;
      e.pos_y = cur_y;
      e.heading = head;
      e.crossings = turns[3:0];
      e.moved = moved;
      e.stopped = !active;
   endtask

   task automatic log_mismatch(input string msg);
      $display("tb: mismatch at %0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         log_mismatch($sformatf("%s got %0d want %0d", name, got, want));
      end
   endtask

   // A pixel may hold 255, or be a start point, only once its whole window is loaded.
   function automatic bit is_safe(input int x, input int y);
      int i;
      int j;
      if (!in_image(x, y)) begin
         return 1'b0;
      end
      for (j = -2; j <= 2; j++) begin
         for (i = -2; i <= 2; i++) begin
            if (in_image(x + i, y + j) && !px_loaded[(y + j) * IMG_WIDTH_DEF + x + i]) begin
               return 1'b0;
            end
         end
      end
      return 1'b1;
   endfunction

   task automatic queue_item(input logic [1:0] f, input int x, input int y, input int v);
      req_type item;
      item.func = f;
      item.coord_x = x[6:0];
      item.coord_y = y[6:0];
      item.pixel_value = v[7:0];
      cmd_queue.push_back(item);
      if (f == FUNC_WRITE) begin
         px_loaded[y * IMG_WIDTH_DEF + x] = 1'b1;
      end
      stim_count++;
   endtask

   // Work areas: the four corners and one patch in the middle of the image.
   task automatic area_of(input int k, output int x0, output int y0, output int n);
      case (k)
         0: begin x0 = 0;   y0 = 0;   n = 10; end
         1: begin x0 = 118; y0 = 0;   n = 10; end
         2: begin x0 = 0;   y0 = 118; n = 10; end
         3: begin x0 = 118; y0 = 118; n = 10; end
         default: begin x0 = 58; y0 = 58; n = 12; end
      endcase
   endtask

   task automatic pick_spot(output int x, output int y);
      int x0;
      int y0;
      int n;
      area_of($urandom_range(0, 4), x0, y0, n);
      do begin
         x = x0 + $urandom_range(0, n - 1);
         y = y0 + $urandom_range(0, n - 1);
      end while (!is_safe(x, y));
   endtask

   // Draw a random walk of line pixels, track it from one of its points, maybe erase it.
   task automatic queue_trace();
      int px[$];
      int py[$];
      int x;
      int y;
      int nx;
      int ny;
      int d;
      int len;
      int tries;
      int k;
      int pick;
      pick_spot(x, y);
      len = $urandom_range(2, 10);
      px.push_back(x);
      py.push_back(y);
      queue_item(FUNC_WRITE, x, y, PIX_ON);
      for (k = 1; k < len; k++) begin
         for (tries = 0; tries < 8; tries++) begin
            d = $urandom_range(1, 8);
            nx = x + step_x(d);
            ny = y + step_y(d);
            if (is_safe(nx, ny)) begin
               break;
            end
         end
         if (tries == 8) begin
            break;
         end
         x = nx;
         y = ny;
         px.push_back(x);
         py.push_back(y);
         queue_item(FUNC_WRITE, x, y, PIX_ON);
      end
      // Now and then break the line so that tracking runs into a pixel that is not on the line.
      if ($urandom_range(0, 5) == 0) begin
         pick = $urandom_range(0, px.size() - 1);
         queue_item(FUNC_WRITE, px[pick], py[pick], $urandom_range(0, 254));
      end
      pick = ($urandom_range(0, 2) == 0) ? $urandom_range(0, px.size() - 1) : 0;
      queue_item(FUNC_START, px[pick], py[pick], $urandom_range(0, 255));
      repeat (px.size() + $urandom_range(0, 3)) begin
         queue_item(FUNC_STEP, $urandom_range(0, 127), $urandom_range(0, 127),
                    $urandom_range(0, 255));
      end
      if ($urandom_range(0, 1) == 0) begin
         foreach (px[i]) begin
            queue_item(FUNC_WRITE, px[i], py[i], 0);
         end
      end
   endtask

   // Build the whole command list, then release reset and wait for the last result.
   initial begin
      int k;
      int x;
      int y;
      int v;
      int x0;
      int y0;
      int n;
      int choice;

      // Load every work area: sparse noise in the corners, dark in the middle.
      for (k = 0; k < 5; k++) begin
         area_of(k, x0, y0, n);
         for (y = y0; y < y0 + n; y++) begin
            for (x = x0; x < x0 + n; x++) begin
               v = (k < 4 && $urandom_range(0, 3) == 0) ? $urandom_range(0, 254) : 0;
               queue_item(FUNC_WRITE, x, y, v);
            end
         end
      end

      // Directed items: ignored code, idle step, image corners, dark start, junction.
      queue_item(FUNC_BAD, 127, 127, 255);
      queue_item(FUNC_STEP, 127, 127, 255);
      queue_item(FUNC_WRITE, 0, 0, PIX_ON);
      queue_item(FUNC_WRITE, 1, 1, PIX_ON);
      queue_item(FUNC_START, 0, 0, 0);
      queue_item(FUNC_STEP, 0, 0, 0);
      queue_item(FUNC_STEP, 0, 0, 0);
      queue_item(FUNC_WRITE, 127, 127, PIX_ON);
      queue_item(FUNC_START, 127, 127, 255);
      queue_item(FUNC_STEP, 127, 127, 255);
      queue_item(FUNC_WRITE, 4, 4, PIX_MARK);
      queue_item(FUNC_START, 4, 4, 0);
      queue_item(FUNC_STEP, 4, 4, 0);
      queue_item(FUNC_WRITE, 63, 63, PIX_ON);
      for (k = 1; k <= 2; k++) begin
         queue_item(FUNC_WRITE, 63, 63 - k, PIX_ON);
         queue_item(FUNC_WRITE, 63 + k, 63, PIX_ON);
         queue_item(FUNC_WRITE, 63, 63 + k, PIX_ON);
         queue_item(FUNC_WRITE, 63 - k, 63, PIX_ON);
      end
      queue_item(FUNC_START, 63, 63, 0);
      queue_item(FUNC_STEP, 63, 63, 0);
      queue_item(FUNC_STEP, 63, 63, 0);

      // Random part until the item total is reached: mostly drawn lines that get
      // tracked, the rest loose commands.
      while (stim_count < TOTAL_ITEMS) begin
         choice = $urandom_range(0, 9);
         if (choice <= 6) begin
            queue_trace();
         end else if (choice == 7) begin
            x = $urandom_range(0, 127);
            y = $urandom_range(0, 127);
            v = $urandom_range(0, 255);
            if (v == PIX_ON && !is_safe(x, y)) begin
               v = $urandom_range(0, 254);
            end
            queue_item(FUNC_WRITE, x, y, v);
         end else if (choice == 8) begin
            pick_spot(x, y);
            queue_item(FUNC_START, x, y, $urandom_range(0, 255));
            repeat ($urandom_range(1, 4)) begin
               queue_item(FUNC_STEP, $urandom_range(0, 127), $urandom_range(0, 127),
                          $urandom_range(0, 255));
            end
         end else begin
            queue_item(($urandom_range(0, 1) == 0) ? FUNC_BAD : FUNC_STEP,
                       $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 255));
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (cmd_queue.size() == 0 && taken_count == sent_count);
      wait (expected_pos_q.size() == 0);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // Command driver: bursts of random length with random gaps in between.
   int burst_left = 0;
   int gap_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && taken_count != sent_count) begin
         // The item on the bus has not been taken yet; hold it.
      end else if (gap_left > 0) begin
         gap_left--;
         start <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
         req_data <= cmd_queue.pop_front();
         start <= 1'b1;
         sent_count++;
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
         end
      end else begin
         start <= 1'b0;
      end
   end

   // Result monitor: check each strobe against the oldest prediction, then log new items.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_pos_q.size() == 0) begin
               log_mismatch("result with no item outstanding");
            end else begin
               want = expected_pos_q.pop_front();
               check_field("pos_x", rsp_data.pos_x, want.pos_x);
               check_field("pos_y", rsp_data.pos_y, want.pos_y);
               check_field("heading", rsp_data.heading, want.heading);
               check_field("crossings", rsp_data.crossings, want.crossings);
               check_field("moved", rsp_data.moved, want.moved);
               check_field("stopped", rsp_data.stopped, want.stopped);
            end
         end
         if (start && !busy) begin
            trace_predict(req_data, want);
            expected_pos_q.push_back(want);
            taken_count++;
         end
      end
   end

   // Watchdog.
   initial begin
      #(5_000_000);
      $display("tb: done, errors");
      $finish;
   end

endmodule
